// ===== sv/sva_pkg.sv =====
// shared constants, types and arctangent table for the signed vector angle block
// no dependencies; imported by signed_vector_angle_top
`default_nettype none

package sva_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;

   // angle in units of 2^-24 rad
   localparam int ANGLE_W   = 28;
   localparam int PI_Z      = 52707179;
   localparam int HALF_PI_Z = 26353589;
   localparam int MAG_W     = 26;

   localparam int OUT_W         = 16;
   localparam int QUO_W         = 16;
   localparam int RAD_SHIFT     = 11;
   localparam int DEG_HALF_TURN = 23040;
   localparam int DEG_ROUND     = PI_Z / 2;

   // reciprocal estimate of 23040 / pi_z, corrected by one remainder check
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 21;
   localparam int DEG_RECIP   = int'(((longint'(DEG_HALF_TURN) << RECIP_SHIFT)
                                       + longint'(PI_Z / 2)) / longint'(PI_Z));
   localparam int NUM_W  = 41;
   localparam int EST_W  = RECIP_W + MAG_W;
   localparam int BACK_W = QUO_W + MAG_W;

   typedef enum logic [1:0] {
      KIND_ANGLE,
      KIND_ZERO,
      KIND_PI
   } kind_type;

   function automatic logic signed [ANGLE_W-1:0] atan_entry(input int unsigned idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         0:       val = 28'sd13176795;
         1:       val = 28'sd7778716;
         2:       val = 28'sd4110060;
         3:       val = 28'sd2086331;
         4:       val = 28'sd1047214;
         5:       val = 28'sd524117;
         6:       val = 28'sd262123;
         7:       val = 28'sd131069;
         8:       val = 28'sd65536;
         9:       val = 28'sd32768;
         10:      val = 28'sd16384;
         11:      val = 28'sd8192;
         12:      val = 28'sd4096;
         13:      val = 28'sd2048;
         14:      val = 28'sd1024;
         15:      val = 28'sd512;
         16:      val = 28'sd256;
         17:      val = 28'sd128;
         18:      val = 28'sd64;
         19:      val = 28'sd32;
         20:      val = 28'sd16;
         21:      val = 28'sd8;
         22:      val = 28'sd4;
         23:      val = 28'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== sv/signed_vector_angle_top.sv =====
// signed angle between two 2-d vectors: products, prerotation, normalization,
// pipelined cordic vectoring and unit conversion; depends on sva_pkg
// pipelined: one register stage per cordic iteration and per normalization shift step
// throughput: one request per cycle; a stalled response stops each stage once it fills
// reset: synchronous, clears all valid bits and sets the angle unit to radians
`default_nettype none

module signed_vector_angle_top #(
   parameter int COORD_WIDTH  = sva_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STEPS = sva_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic csr_write_data,
   input  logic req_tvalid,
   output logic req_tready,
   // first_x, first_y, second_x, second_y from the lowest bit up
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // signed_angle
   output logic [sva_pkg::OUT_W-1:0] rsp_tdata
);
   import sva_pkg::*;

   localparam int PW       = 2 * COORD_WIDTH;
   localparam int DW       = PW + 1;
   localparam int XW       = PW + 3;
   localparam int NS       = $clog2(PW - 1);
   localparam int ST_MUL   = 0;
   localparam int ST_DOT   = 1;
   localparam int ST_ROT   = 2;
   localparam int ST_ZC    = ST_ROT + NS + CORDIC_STEPS + 1;
   localparam int ST_SCALE = ST_ZC + 1;
   localparam int ST_EST   = ST_ZC + 2;
   localparam int ST_BACK  = ST_ZC + 3;
   localparam int ST_OUT   = ST_ZC + 4;
   localparam int NUM_ST   = ST_OUT + 1;

   localparam logic signed [ANGLE_W-1:0] PI_A      = ANGLE_W'(PI_Z);
   localparam logic signed [ANGLE_W-1:0] HALF_PI_A = ANGLE_W'(HALF_PI_Z);
   localparam logic signed [BACK_W:0]    PI_REM    = (BACK_W+1)'(PI_Z);

   typedef struct packed {
      logic signed [XW-1:0]      x;
      logic signed [XW-1:0]      y;
      logic signed [ANGLE_W-1:0] z;
      kind_type                  kind;
   } vec_type;

   // stage handshake
   logic [NUM_ST-1:0] valid_ff;
   logic [NUM_ST-1:0] valid_up;
   logic [NUM_ST:0]   ready;

   assign ready[NUM_ST] = rsp_tready;
   assign valid_up      = {valid_ff[NUM_ST-2:0], req_tvalid};

   for (genvar k = 0; k < NUM_ST; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_ST; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_up[k];
            end
         end
      end
   end

   assign req_tready = ready[ST_MUL];
   assign rsp_tvalid = valid_ff[ST_OUT];

   // angle unit register
   logic angle_unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_unit_ff <= 1'b0;
      end else if (csr_write_en) begin
         angle_unit_ff <= csr_write_data;
      end
   end

   // products
   logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;
   logic signed [PW-1:0]          prod_ff [4];

   assign first_x  = $signed(req_tdata[COORD_WIDTH-1:0]);
   assign first_y  = $signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
   assign second_x = $signed(req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);
   assign second_y = $signed(req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]);

   always_ff @(posedge clock) begin
      if (ready[ST_MUL]) begin
         prod_ff[0] <= PW'(first_x * second_x);
         prod_ff[1] <= PW'(first_y * second_y);
         prod_ff[2] <= PW'(first_x * second_y);
         prod_ff[3] <= PW'(first_y * second_x);
      end
   end

   // dot and cross
   logic signed [DW-1:0] dot_ff, cross_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_DOT]) begin
         dot_ff   <= DW'(prod_ff[0]) + DW'(prod_ff[1]);
         cross_ff <= DW'(prod_ff[2]) - DW'(prod_ff[3]);
      end
   end

   // prerotation into the right half plane
   vec_type pipe_ff [NS+CORDIC_STEPS+1];
   vec_type rot_in;

   always_comb begin
      rot_in.x    = XW'(dot_ff);
      rot_in.y    = XW'(cross_ff);
      rot_in.z    = '0;
      rot_in.kind = KIND_ANGLE;
      if (dot_ff < 0) begin
         if (cross_ff >= 0) begin
            rot_in.x = XW'(cross_ff);
            rot_in.y = -XW'(dot_ff);
            rot_in.z = HALF_PI_A;
         end else begin
            rot_in.x = -XW'(cross_ff);
            rot_in.y = XW'(dot_ff);
            rot_in.z = -HALF_PI_A;
         end
      end
      if (cross_ff == '0) begin
         rot_in.kind = (dot_ff < 0) ? KIND_PI : KIND_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[ST_ROT]) begin
         pipe_ff[0] <= rot_in;
      end
   end

   // normalization, one binary shift step per stage
   for (genvar m = 1; m <= NS; m++) begin : g_norm
      localparam int SH = 1 << (NS - m);
      localparam logic signed [XW-1:0] LIM  = XW'(1) <<< (PW - 1 - SH);
      localparam logic signed [XW-1:0] NLIM = -LIM;
      vec_type prev;
      vec_type stage_in;
      logic    fits;

      always_comb begin
         prev     = pipe_ff[m-1];
         fits     = (prev.x < LIM) && (prev.y < LIM) && (prev.y > NLIM);
         stage_in = prev;
         if (fits) begin
            stage_in.x = prev.x <<< SH;
            stage_in.y = prev.y <<< SH;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[ST_ROT+m]) begin
            pipe_ff[m] <= stage_in;
         end
      end
   end

   // cordic vectoring iterations
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam int M = NS + 1 + i;
      vec_type              prev;
      vec_type              stage_in;
      logic signed [XW-1:0] xs, ys;

      always_comb begin
         prev     = pipe_ff[M-1];
         xs       = prev.x >>> i;
         ys       = prev.y >>> i;
         stage_in = prev;
         if (!prev.y[XW-1]) begin
            stage_in.x = prev.x + ys;
            stage_in.y = prev.y - xs;
            stage_in.z = prev.z + atan_entry(i);
         end else begin
            stage_in.x = prev.x - ys;
            stage_in.y = prev.y + xs;
            stage_in.z = prev.z - atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (ready[ST_ROT+M]) begin
            pipe_ff[M] <= stage_in;
         end
      end
   end

   // special cases, clamp and magnitude
   vec_type                   last;
   logic signed [ANGLE_W-1:0] zc, zabs;
   logic                      neg_zc_ff;
   logic [MAG_W-1:0]          mag_zc_ff;

   always_comb begin
      last = pipe_ff[NS+CORDIC_STEPS];
      case (last.kind)
         KIND_ZERO: zc = '0;
         KIND_PI:   zc = PI_A;
         default: begin
            if (last.z > PI_A) begin
               zc = PI_A;
            end else if (last.z < -PI_A) begin
               zc = -PI_A;
            end else begin
               zc = last.z;
            end
         end
      endcase
      zabs = (zc < 0) ? -zc : zc;
   end

   always_ff @(posedge clock) begin
      if (ready[ST_ZC]) begin
         neg_zc_ff <= zc[ANGLE_W-1];
         mag_zc_ff <= zabs[MAG_W-1:0];
      end
   end

   // unit scaling
   logic             neg_sc_ff;
   logic [NUM_W-1:0] num_sc_ff;
   logic [EST_W-1:0] est_sc_ff;
   logic [QUO_W-1:0] rad_sc_ff;
   logic [MAG_W:0]   rad_sum;

   assign rad_sum = {1'b0, mag_zc_ff} + (MAG_W+1)'(1 << (RAD_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (ready[ST_SCALE]) begin
         neg_sc_ff <= neg_zc_ff;
         num_sc_ff <= NUM_W'(mag_zc_ff) * NUM_W'(DEG_HALF_TURN) + NUM_W'(DEG_ROUND);
         est_sc_ff <= EST_W'(mag_zc_ff) * EST_W'(DEG_RECIP);
         rad_sc_ff <= QUO_W'(rad_sum >> RAD_SHIFT);
      end
   end

   // quotient estimate
   logic             neg_es_ff;
   logic [NUM_W-1:0] num_es_ff;
   logic [QUO_W-1:0] quo_es_ff;
   logic [QUO_W-1:0] rad_es_ff;
   logic [EST_W:0]   est_sum;

   assign est_sum = {1'b0, est_sc_ff} + ((EST_W+1)'(1) << (RECIP_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (ready[ST_EST]) begin
         neg_es_ff <= neg_sc_ff;
         num_es_ff <= num_sc_ff;
         quo_es_ff <= QUO_W'(est_sum >> RECIP_SHIFT);
         rad_es_ff <= rad_sc_ff;
      end
   end

   // back multiplication
   logic              neg_bk_ff;
   logic [NUM_W-1:0]  num_bk_ff;
   logic [QUO_W-1:0]  quo_bk_ff;
   logic [BACK_W-1:0] back_bk_ff;
   logic [QUO_W-1:0]  rad_bk_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_BACK]) begin
         neg_bk_ff  <= neg_es_ff;
         num_bk_ff  <= num_es_ff;
         quo_bk_ff  <= quo_es_ff;
         back_bk_ff <= BACK_W'(quo_es_ff) * BACK_W'(PI_Z);
         rad_bk_ff  <= rad_es_ff;
      end
   end

   // remainder correction, unit select and sign
   logic signed [BACK_W:0] rem;
   logic [QUO_W-1:0]       deg, res_mag;
   logic [OUT_W-1:0]       rsp_data_ff, rsp_data_in;

   always_comb begin
      rem = $signed((BACK_W+1)'(num_bk_ff)) - $signed((BACK_W+1)'(back_bk_ff));
      if (rem < 0) begin
         deg = quo_bk_ff - QUO_W'(1);
      end else if (rem >= PI_REM) begin
         deg = quo_bk_ff + QUO_W'(1);
      end else begin
         deg = quo_bk_ff;
      end
      res_mag     = angle_unit_ff ? deg : rad_bk_ff;
      rsp_data_in = neg_bk_ff ? OUT_W'(-res_mag) : OUT_W'(res_mag);
   end

   always_ff @(posedge clock) begin
      if (ready[ST_OUT]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/signed_vector_angle_top_tb.sv =====
// testbench for signed_vector_angle_top: drives vector pairs over the request stream,
// predicts each angle with a cycle-free cordic vectoring model and checks responses in order
// depends on sva_pkg and signed_vector_angle_top
`timescale 1ns / 1ps

module signed_vector_angle_top_tb;

   localparam int  COORD_W       = 16;
   localparam int  DATA_W        = ((4 * COORD_W + 7) / 8) * 8;
   localparam int  STEPS         = 16;
   localparam longint PI_ANGLE   = 52707179;
   localparam longint HALF_PI    = 26353589;
   localparam longint NORM_LIMIT = longint'(1) << (2 * COORD_W - 2);
   localparam longint DEG_PI_OUT = 23040;
   localparam longint RAD_PI_OUT = 25736;
   localparam longint RAD_DIV    = 2048;
   localparam logic   UNIT_RAD   = 1'b0;
   localparam logic   UNIT_DEG   = 1'b1;
   localparam int  QUIET_LIMIT   = 3000;
   localparam int  DRAIN_CYCLES  = 40;

   class angle_scoreboard;
      logic angle_unit;
      int   errors;
      logic [sva_pkg::OUT_W-1:0] expected_angles[$];
      longint atan_step[24] = '{
         13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
         65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
         256, 128, 64, 32, 16, 8, 4, 2
      };

      function new();
         angle_unit = UNIT_RAD;
         errors     = 0;
      endfunction

      function logic [sva_pkg::OUT_W-1:0] predict_angle(
         input logic signed [COORD_W-1:0] ax, ay, bx, by);
         longint dot, cross_prod, x, y, t, ymag, xs, ys, z, num, den, q, lim;
         dot        = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
         cross_prod = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
         z = 0;
         if (cross_prod == 0) begin
            z = (dot < 0) ? PI_ANGLE : 0;
         end else begin
            x = dot;
            y = cross_prod;
            // turn into the right half plane
            if (x < 0) begin
               t = x;
               if (y >= 0) begin
                  x = y;
                  y = -t;
                  z = HALF_PI;
               end else begin
                  x = -y;
                  y = t;
                  z = -HALF_PI;
               end
            end
            ymag = (y < 0) ? -y : y;
            while (((x > ymag) ? x : ymag) < NORM_LIMIT) begin
               x    = x * 2;
               y    = y * 2;
               ymag = ymag * 2;
            end
            for (int i = 0; i < STEPS; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + atan_step[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - atan_step[i];
               end
            end
            if (z > PI_ANGLE) z = PI_ANGLE;
            if (z < -PI_ANGLE) z = -PI_ANGLE;
         end
         if (angle_unit == UNIT_DEG) begin
            num = z * DEG_PI_OUT;
            den = PI_ANGLE;
            lim = DEG_PI_OUT;
         end else begin
            num = z;
            den = RAD_DIV;
            lim = RAD_PI_OUT;
         end
         // round to nearest, ties away from zero
         q = (((num < 0) ? -num : num) + den / 2) / den;
         if (num < 0) q = -q;
         if (q > lim) q = lim;
         if (q < -lim) q = -lim;
         return q[sva_pkg::OUT_W-1:0];
      endfunction

      function void note_request(input logic signed [COORD_W-1:0] ax, ay, bx, by);
         expected_angles.push_back(predict_angle(ax, ay, bx, by));
      endfunction

      function void check_response(input logic [sva_pkg::OUT_W-1:0] got);
         logic [sva_pkg::OUT_W-1:0] want;
         if (expected_angles.size() == 0) begin
            $error("signed_angle: expected none, got %0d", $signed(got));
            errors++;
         end else begin
            want = expected_angles.pop_front();
            if (got !== want) begin
               $error("signed_angle: expected %0d, got %0d", $signed(want), $signed(got));
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;
   logic req_tvalid;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [sva_pkg::OUT_W-1:0] rsp_tdata;

   angle_scoreboard angles = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   signed_vector_angle_top DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) angles.check_response(rsp_tdata);
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic signed [COORD_W-1:0] ax, ay, bx, by);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {by, bx, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      angles.note_request(ax, ay, bx, by);
      @(negedge clock);
   endtask

   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (angles.expected_angles.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_unit(input logic unit);
      stop_requests();
      wait_drained();
      repeat (4) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= unit;
      angles.angle_unit = unit;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_directed();
      send_request(0, 0, 0, 0);
      send_request(0, 0, 5, 7);
      send_request(1, 0, 1, 0);
      send_request(3, 4, 6, 8);
      send_request(1, 0, -1, 0);
      send_request(-32768, -32768, 32767, 32767);
      send_request(-32768, -32768, -32768, -32768);
      send_request(1, 0, 0, 1);
      send_request(1, 0, 0, -1);
      send_request(1, 0, -32768, -1);
      send_request(1, 0, -32768, 1);
      send_request(32767, 0, -32768, -1);
      send_request(-32768, 32767, 32767, -32768);
      send_request(32767, -32768, -32768, 32767);
      send_request(-1, -1, -1, -1);
      send_request(0, 1, -1, 0);
      send_request(-1, 0, 0, -1);
      send_request(5, -3, -2, 7);
      send_request(32767, 32767, 32767, -32768);
      send_request(-32768, 0, 0, -32768);
   endtask

   task automatic run_random(input int count, input int pause_at);
      logic signed [COORD_W-1:0] ax, ay, bx, by;
      logic signed [COORD_W-1:0] corner[6];
      int pick, k;
      corner = '{-32768, -32767, -1, 0, 1, 32767};
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) begin
            stop_requests();
            wait_drained();
         end
         pick = $urandom_range(99);
         ax = COORD_W'($urandom);
         ay = COORD_W'($urandom);
         bx = COORD_W'($urandom);
         by = COORD_W'($urandom);
         if (pick < 40) begin
            // full range as drawn
         end else if (pick < 55) begin
            ax = COORD_W'(int'($urandom_range(16)) - 8);
            ay = COORD_W'(int'($urandom_range(16)) - 8);
            bx = COORD_W'(int'($urandom_range(16)) - 8);
            by = COORD_W'(int'($urandom_range(16)) - 8);
         end else if (pick < 70) begin
            // parallel or antiparallel pair
            ax = COORD_W'(int'($urandom_range(4000)) - 2000);
            ay = COORD_W'(int'($urandom_range(4000)) - 2000);
            k  = int'($urandom_range(30)) - 15;
            bx = COORD_W'(ax * k);
            by = COORD_W'(ay * k);
         end else if (pick < 80) begin
            ax = corner[$urandom_range(5)];
            ay = corner[$urandom_range(5)];
            bx = corner[$urandom_range(5)];
            by = corner[$urandom_range(5)];
         end else if (pick < 90) begin
            // nearly opposite, angle close to either side of pi
            ay = COORD_W'(int'(ay) / 2);
            ax = COORD_W'(int'(ax) / 2);
            bx = COORD_W'(-int'(ax) + int'($urandom_range(6)) - 3);
            by = COORD_W'(-int'(ay) + int'($urandom_range(6)) - 3);
         end else begin
            ay = COORD_W'(int'(ay) / 2);
            ax = COORD_W'(int'(ax) / 2);
            bx = COORD_W'(-int'(ay) + int'($urandom_range(6)) - 3);
            by = COORD_W'(int'(ax) + int'($urandom_range(6)) - 3);
         end
         send_request(ax, ay, bx, by);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_write_data <= 1'b0;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_unit(UNIT_RAD);
      run_directed();
      run_random(130, -1);

      write_unit(UNIT_DEG);
      send_idle_pct = 67;
      run_directed();
      run_random(130, 60);

      write_unit(UNIT_RAD);
      send_idle_pct = 0;
      stall_pct     = 67;
      run_random(130, -1);

      write_unit(UNIT_DEG);
      send_idle_pct = 9;
      stall_pct     = 9;
      run_random(130, -1);

      write_unit(UNIT_RAD);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(130, -1);

      stop_requests();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (angles.expected_angles.size() != 0) angles.errors++;
      if (angles.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
